// ----- sv/gdda_pkg.sv -----
// shared types and constants for the grid ray dda block
package gdda_pkg;

	localparam int MAP_SIDE_BITS = 6;
	localparam int MAX_STEPS     = 128;
	localparam int CELL_ADDR_W   = 2 * MAP_SIDE_BITS;
	localparam int CELL_W        = 11;
	localparam int STEP_CNT_W    = $clog2(MAX_STEPS + 1);

	localparam logic [MAP_SIDE_BITS-1:0] COORD_MAX = '1;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_CAST = 1'b1;

	localparam logic SIDE_X = 1'b0;
	localparam logic SIDE_Y = 1'b1;

	localparam logic STATUS_HIT  = 1'b0;
	localparam logic STATUS_MISS = 1'b1;

	localparam int CELL_SOLID_BIT = 0;
	localparam int CELL_DOOR_BIT  = 1;

	typedef struct packed {
		logic               action;
		logic [11:0]        tile;
		logic [10:0]        cell_word;
		logic [1:0]         step_signs;
		logic [31:0]        delta_x;
		logic [31:0]        delta_y;
		logic [31:0]        side_x;
		logic [31:0]        side_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [21:0]        pos_x;
		logic [21:0]        pos_y;
	} cmd_t;

	typedef struct packed {
		logic [31:0] distance;
		logic        side;
		logic [5:0]  hit_x;
		logic [5:0]  hit_y;
		logic        status;
	} res_t;

	typedef struct packed {
		logic                     pick_x;
		logic [31:0]              reach;
		logic [31:0]              side_next;
		logic [MAP_SIDE_BITS-1:0] coord_next;
		logic                     leave;
	} walk_t;

endpackage

// ----- sv/gdda_map_ram.sv -----
// tile map memory, one write port and one registered read port
module gdda_map_ram (
	input  logic                            clk,
	input  logic                            we,
	input  logic [gdda_pkg::CELL_ADDR_W-1:0] waddr,
	input  logic [gdda_pkg::CELL_W-1:0]      wdata,
	input  logic                            re,
	input  logic [gdda_pkg::CELL_ADDR_W-1:0] raddr,
	output logic [gdda_pkg::CELL_W-1:0]      rdata
);

	logic [gdda_pkg::CELL_W-1:0] mem [0:(1 << gdda_pkg::CELL_ADDR_W)-1];
	logic [gdda_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/gdda_walk_unit.sv -----
// shared dda step unit: axis choice, saturating side add and coordinate step
module gdda_walk_unit (
	input  logic [31:0]                        side_x,
	input  logic [31:0]                        side_y,
	input  logic [31:0]                        delta_x,
	input  logic [31:0]                        delta_y,
	input  logic [gdda_pkg::MAP_SIDE_BITS-1:0] x,
	input  logic [gdda_pkg::MAP_SIDE_BITS-1:0] y,
	input  logic                               neg_x,
	input  logic                               neg_y,
	output gdda_pkg::walk_t                    walk
);

	logic                               pick_x;
	logic [31:0]                        add_a;
	logic [31:0]                        add_b;
	logic [32:0]                        sum;
	logic [gdda_pkg::MAP_SIDE_BITS-1:0] coord;
	logic                               neg;

	always_comb begin
		pick_x = side_x < side_y;
		add_a  = pick_x ? side_x : side_y;
		add_b  = pick_x ? delta_x : delta_y;
		coord  = pick_x ? x : y;
		neg    = pick_x ? neg_x : neg_y;
		sum    = {1'b0, add_a} + {1'b0, add_b};

		walk.pick_x    = pick_x;
		walk.reach     = add_a;
		walk.side_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (neg) begin
			walk.leave      = coord == '0;
			walk.coord_next = coord - gdda_pkg::MAP_SIDE_BITS'(1);
		end else begin
			walk.leave      = coord == gdda_pkg::COORD_MAX;
			walk.coord_next = coord + gdda_pkg::MAP_SIDE_BITS'(1);
		end
	end

endmodule

// ----- sv/gdda_door_unit.sv -----
// door test: registered distance by direction product, then fraction compare
module gdda_door_unit (
	input  logic               clk,
	input  logic               load,
	input  logic [31:0]        reach,
	input  logic signed [15:0] dir,
	input  logic [15:0]        pos,
	input  logic [8:0]         closed,
	output logic               hit
);

	logic signed [48:0] prod;
	logic [15:0]        prod_q;
	logic [15:0]        frac;

	assign prod = $signed({1'b0, reach}) * dir;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod[29:14];
		end
	end

	assign frac = prod_q + pos;
	assign hit  = {1'b0, frac} <= {closed, 8'h00};

endmodule

// ----- sv/grid_ray_dda_with_doors_core.sv -----
// top level of the grid ray dda block with doors
//
// cmd channel (cmd_valid, cmd_stall, cmd): a load transaction writes one map tile
// and gives no result; a cast transaction walks a ray and gives exactly one
// transaction on the res channel (res_valid, res_stall, res).
// each tile stepped goes through the step and test states, and a door tile adds the
// check state; the step unit and the single map read port are used once per step,
// and at most 128 steps are taken. cmd_stall stays high while a cast is walking.
// the result sits in an output register; further loads are taken while it waits, and
// a finished cast waits there until res_stall drops.
// after reset the whole map is cleared one tile a cycle, with cmd_stall high.
// a walk that leaves the map or runs 128 steps without a hit reports status miss with
// the other fields zero.
module grid_ray_dda_with_doors_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  gdda_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output gdda_pkg::res_t res
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_STEP  = 6'b000100,
		ST_TEST  = 6'b001000,
		ST_CHECK = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [gdda_pkg::CELL_ADDR_W-1:0]   clr_q;
	logic [gdda_pkg::STEP_CNT_W-1:0]    n_q;
	logic [31:0]                        side_x_q;
	logic [31:0]                        side_y_q;
	logic [31:0]                        delta_x_q;
	logic [31:0]                        delta_y_q;
	logic [gdda_pkg::MAP_SIDE_BITS-1:0] x_q;
	logic [gdda_pkg::MAP_SIDE_BITS-1:0] y_q;
	logic                               neg_x_q;
	logic                               neg_y_q;
	logic signed [15:0]                 dir_x_q;
	logic signed [15:0]                 dir_y_q;
	logic [15:0]                        pos_x_q;
	logic [15:0]                        pos_y_q;
	logic [31:0]                        dist_q;
	logic                               side_q;
	logic                               hit_q;
	logic                               res_valid_q;
	gdda_pkg::res_t                     res_q;

	logic                               cmd_take;
	logic                               res_free;
	logic                               last_step;
	logic [gdda_pkg::MAP_SIDE_BITS-1:0] cmd_x;
	logic [gdda_pkg::MAP_SIDE_BITS-1:0] cmd_y;
	gdda_pkg::walk_t                    walk;
	logic                               ram_we;
	logic [gdda_pkg::CELL_ADDR_W-1:0]   ram_waddr;
	logic [gdda_pkg::CELL_W-1:0]        ram_wdata;
	logic                               ram_re;
	logic [gdda_pkg::CELL_ADDR_W-1:0]   ram_raddr;
	logic [gdda_pkg::CELL_W-1:0]        tile_data;
	logic                               door_hit;

	assign cmd_stall = state_q != ST_IDLE;
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign last_step = n_q == gdda_pkg::STEP_CNT_W'(gdda_pkg::MAX_STEPS);
	assign cmd_x     = gdda_pkg::MAP_SIDE_BITS'(cmd.tile);
	assign cmd_y     = gdda_pkg::MAP_SIDE_BITS'(cmd.tile >> gdda_pkg::MAP_SIDE_BITS);

	gdda_walk_unit u_walk (
		.side_x  (side_x_q),
		.side_y  (side_y_q),
		.delta_x (delta_x_q),
		.delta_y (delta_y_q),
		.x       (x_q),
		.y       (y_q),
		.neg_x   (neg_x_q),
		.neg_y   (neg_y_q),
		.walk    (walk)
	);

	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || (cmd_take && cmd.action == gdda_pkg::ACT_LOAD);
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : {cmd_y, cmd_x};
		ram_wdata = (state_q == ST_CLEAR) ? '0 : cmd.cell_word;
		ram_re    = (state_q == ST_STEP) && !walk.leave;
		ram_raddr = walk.pick_x ? {y_q, walk.coord_next} : {walk.coord_next, x_q};
	end

	gdda_map_ram u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (tile_data)
	);

	gdda_door_unit u_door (
		.clk    (clk),
		.load   (state_q == ST_TEST),
		.reach  (dist_q),
		.dir    ((side_q == gdda_pkg::SIDE_X) ? dir_y_q : dir_x_q),
		.pos    ((side_q == gdda_pkg::SIDE_X) ? pos_y_q : pos_x_q),
		.closed (tile_data[10:2]),
		.hit    (door_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			n_q     <= '0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + gdda_pkg::CELL_ADDR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_take && cmd.action == gdda_pkg::ACT_CAST) begin
						n_q     <= '0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					n_q <= n_q + gdda_pkg::STEP_CNT_W'(1);
					if (walk.leave) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (tile_data[gdda_pkg::CELL_DOOR_BIT]) begin
						state_q <= ST_CHECK;
					end else if (tile_data[gdda_pkg::CELL_SOLID_BIT]) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_step) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_CHECK: begin
					if (door_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_step) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.action == gdda_pkg::ACT_CAST) begin
			side_x_q  <= cmd.side_x;
			side_y_q  <= cmd.side_y;
			delta_x_q <= cmd.delta_x;
			delta_y_q <= cmd.delta_y;
			x_q       <= cmd_x;
			y_q       <= cmd_y;
			neg_x_q   <= cmd.step_signs[0];
			neg_y_q   <= cmd.step_signs[1];
			dir_x_q   <= cmd.dir_x;
			dir_y_q   <= cmd.dir_y;
			pos_x_q   <= cmd.pos_x[15:0];
			pos_y_q   <= cmd.pos_y[15:0];
		end else if (state_q == ST_STEP) begin
			dist_q <= walk.reach;
			side_q <= walk.pick_x ? gdda_pkg::SIDE_X : gdda_pkg::SIDE_Y;
			if (walk.pick_x) begin
				side_x_q <= walk.side_next;
				x_q      <= walk.coord_next;
			end else begin
				side_y_q <= walk.side_next;
				y_q      <= walk.coord_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && res_free) begin
			res_q.distance <= hit_q ? dist_q : '0;
			res_q.side     <= hit_q ? side_q : 1'b0;
			res_q.hit_x    <= hit_q ? 6'(x_q) : '0;
			res_q.hit_y    <= hit_q ? 6'(y_q) : '0;
			res_q.status   <= hit_q ? gdda_pkg::STATUS_HIT : gdda_pkg::STATUS_MISS;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (n_q < gdda_pkg::STEP_CNT_W'(gdda_pkg::MAX_STEPS)))
		else $error("step taken past the step limit");

	a_cast_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.action == gdda_pkg::ACT_CAST) |=> (state_q == ST_STEP))
		else $error("cast transaction did not start a walk");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_no_read_on_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && walk.leave) |=> (state_q == ST_DONE && !hit_q))
		else $error("walk leaving the map not reported as a miss");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("stalled result changed");

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the grid ray dda block: directed and random casts checked against a predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gdda_pkg::*;

	localparam int STALL_NONE  = 0;
	localparam int STALL_SHORT = 1;
	localparam int STALL_LONG  = 2;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	logic [CELL_W-1:0] tile_map [0:(1 << CELL_ADDR_W)-1];
	res_t              cast_results_q [$];
	res_t              want_res;
	int                mismatch_count = 0;
	int                burst_left     = 0;
	int                gap_max        = 0;
	int                stall_mode     = STALL_NONE;
	int                stall_left     = 0;

	grid_ray_dda_with_doors_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic res_t predict_cast(input cmd_t c);
		logic [MAP_SIDE_BITS-1:0] cx;
		logic [MAP_SIDE_BITS-1:0] cy;
		logic [31:0]              run_x;
		logic [31:0]              run_y;
		logic [31:0]              reach;
		logic                     step_side;
		logic                     walking;
		logic                     off_map;
		logic                     hit;
		logic [CELL_W-1:0]        cell_v;
		logic signed [15:0]       cross_dir;
		logic [21:0]              cross_pos;
		logic [63:0]              prod;
		logic [15:0]              frac;
		res_t                     r;
		r = '0;
		r.status = STATUS_MISS;
		cx = c.tile[MAP_SIDE_BITS-1:0];
		cy = c.tile[CELL_ADDR_W-1:MAP_SIDE_BITS];
		run_x = c.side_x;
		run_y = c.side_y;
		walking = 1'b1;
		for (int n = 0; n < MAX_STEPS; n++) begin
			if (walking) begin
				off_map = 1'b0;
				if (run_x < run_y) begin
					reach = run_x;
					run_x = sat_add(run_x, c.delta_x);
					step_side = SIDE_X;
					if (c.step_signs[0]) begin
						if (cx == 0) off_map = 1'b1;
						else cx = cx - 1'b1;
					end else begin
						if (cx == COORD_MAX) off_map = 1'b1;
						else cx = cx + 1'b1;
					end
				end else begin
					reach = run_y;
					run_y = sat_add(run_y, c.delta_y);
					step_side = SIDE_Y;
					if (c.step_signs[1]) begin
						if (cy == 0) off_map = 1'b1;
						else cy = cy - 1'b1;
					end else begin
						if (cy == COORD_MAX) off_map = 1'b1;
						else cy = cy + 1'b1;
					end
				end
				if (off_map) begin
					walking = 1'b0;
				end else begin
					cell_v = tile_map[{cy, cx}];
					if (cell_v[CELL_DOOR_BIT]) begin
						cross_dir = (step_side == SIDE_X) ? c.dir_y : c.dir_x;
						cross_pos = (step_side == SIDE_X) ? c.pos_y : c.pos_x;
						prod = longint'({32'b0, reach}) * longint'(cross_dir);
						frac = prod[29:14] + cross_pos[15:0];
						hit = ({1'b0, frac} <= {cell_v[10:2], 8'd0});
					end else begin
						hit = cell_v[CELL_SOLID_BIT];
					end
					if (hit) begin
						r.distance = reach;
						r.side = step_side;
						r.hit_x = cx;
						r.hit_y = cy;
						r.status = STATUS_HIT;
						walking = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.action = 1'($urandom);
		c.tile = 12'($urandom);
		c.cell_word = 11'($urandom);
		c.step_signs = 2'($urandom);
		c.delta_x = $urandom;
		c.delta_y = $urandom;
		c.side_x = $urandom;
		c.side_y = $urandom;
		c.dir_x = 16'($urandom);
		c.dir_y = 16'($urandom);
		c.pos_x = 22'($urandom);
		c.pos_y = 22'($urandom);
		return c;
	endfunction

	function automatic cmd_t load_cmd(input logic [11:0] t, input logic [10:0] w);
		cmd_t c;
		c = '0;
		c.action = ACT_LOAD;
		c.tile = t;
		c.cell_word = w;
		return c;
	endfunction

	function automatic cmd_t cast_cmd(input logic [11:0] t, input logic [1:0] signs,
		input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] sx,
		input logic [31:0] sy, input logic [15:0] drx, input logic [15:0] dry,
		input logic [21:0] px, input logic [21:0] py);
		cmd_t c;
		c = '0;
		c.action = ACT_CAST;
		c.tile = t;
		c.step_signs = signs;
		c.delta_x = dx;
		c.delta_y = dy;
		c.side_x = sx;
		c.side_y = sy;
		c.dir_x = drx;
		c.dir_y = dry;
		c.pos_x = px;
		c.pos_y = py;
		return c;
	endfunction

	// tiles clustered round a centre so that rays meet walls and doors
	function automatic cmd_t room_load(input logic [5:0] cx, input logic [5:0] cy);
		cmd_t       c;
		logic [5:0] x;
		logic [5:0] y;
		logic [10:0] w;
		c = random_cmd();
		c.action = ACT_LOAD;
		x = cx + 6'($urandom_range(0, 8)) - 6'd4;
		y = cy + 6'($urandom_range(0, 8)) - 6'd4;
		case ($urandom_range(0, 9))
			0: w = c.cell_word;
			1, 2, 3, 4: w = {9'($urandom), 1'b0, 1'b1};
			5, 6, 7: w = {9'($urandom_range(0, 300)), 1'b1, 1'($urandom)};
			default: w = {9'($urandom), 2'b00};
		endcase
		if (w != c.cell_word) c.tile = {y, x};
		c.cell_word = w;
		return c;
	endfunction

	function automatic cmd_t room_ray(input logic [5:0] cx, input logic [5:0] cy);
		cmd_t       c;
		logic [5:0] x;
		logic [5:0] y;
		c = random_cmd();
		c.action = ACT_CAST;
		if ($urandom_range(0, 9) != 0) begin
			x = cx + 6'($urandom_range(0, 6)) - 6'd3;
			y = cy + 6'($urandom_range(0, 6)) - 6'd3;
			c.tile = {y, x};
			c.delta_x = $urandom_range(32'h4000, 32'h8_0000);
			c.delta_y = $urandom_range(32'h4000, 32'h8_0000);
			c.side_x = $urandom_range(0, c.delta_x);
			c.side_y = $urandom_range(0, c.delta_y);
			c.pos_x = {x, 16'($urandom)};
			c.pos_y = {y, 16'($urandom)};
		end
		return c;
	endfunction

	task automatic issue_command(input cmd_t c);
		int gap;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		if (c.action == ACT_CAST) cast_results_q.push_back(predict_cast(c));
		else tile_map[c.tile] = c.cell_word;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_for_casts();
		cmd_valid <= 1'b0;
		while (cast_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic note_mismatch(input res_t want, input res_t got, input bit orphan);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (orphan)
				$display("unexpected result: dist=%h side=%0d x=%0d y=%0d status=%0d",
					got.distance, got.side, got.hit_x, got.hit_y, got.status);
			else
				$display("mismatch: exp dist=%h side=%0d x=%0d y=%0d status=%0d, %s%h %s%0d %s%0d %s%0d %s%0d",
					want.distance, want.side, want.hit_x, want.hit_y, want.status,
					"got dist=", got.distance, "side=", got.side, "x=", got.hit_x,
					"y=", got.hit_y, "status=", got.status);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (cast_results_q.size() == 0) begin
				note_mismatch(res, res, 1'b1);
			end else begin
				want_res = cast_results_q.pop_front();
				if (res.distance !== want_res.distance || res.side !== want_res.side ||
					res.hit_x !== want_res.hit_x || res.hit_y !== want_res.hit_y ||
					res.status !== want_res.status)
					note_mismatch(want_res, res, 1'b0);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if (stall_mode != STALL_NONE && $urandom_range(0, 3) == 0) begin
			stall_left <= (stall_mode == STALL_LONG) ? $urandom_range(0, 40) : $urandom_range(0, 2);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic test_empty_map();
		gap_max = 0;
		stall_mode <= STALL_NONE;
		// tie at the corner goes to y and leaves at once
		issue_command(cast_cmd({6'd0, 6'd0}, 2'b11, 32'h1_0000, 32'h1_0000, 32'd0, 32'd0,
			16'h4000, 16'h4000, 22'h0, 22'h0));
		issue_command(cast_cmd(12'hFFF, 2'b00, '1, '1, '1, '1, 16'h8000, 16'h7FFF,
			22'h3F_FFFF, 22'h3F_FFFF));
		// long diagonal walk across the whole map
		issue_command(cast_cmd({6'd0, 6'd0}, 2'b00, 32'h1_8000, 32'h1_C000, 32'h8000,
			32'h4000, 16'h2000, 16'h2000, 22'h0_8000, 22'h0_8000));
	endtask

	task automatic test_solid_and_doors();
		gap_max = 3;
		stall_mode <= STALL_SHORT;
		issue_command(load_cmd({6'd10, 6'd10}, 11'h001));
		issue_command(load_cmd({6'd20, 6'd20}, 11'h402));
		issue_command(load_cmd({6'd30, 6'd30}, 11'h002));
		issue_command(load_cmd({6'd40, 6'd40}, 11'h7FF));
		issue_command(load_cmd({6'd40, 6'd41}, 11'h003));
		issue_command(load_cmd({6'd50, 6'd50}, 11'h202));
		issue_command(cast_cmd({6'd10, 6'd5}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h8000, '1,
			16'h0, 16'h0, 22'h0, 22'h0));
		// a solid start tile is not tested
		issue_command(cast_cmd({6'd10, 6'd10}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h0, '1,
			16'h0, 16'h0, 22'h0, 22'h0));
		issue_command(cast_cmd({6'd20, 6'd19}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h4000, '1,
			16'h3FFF, 16'h1234, 22'h13_8000, 22'h14_C000));
		issue_command(cast_cmd({6'd30, 6'd29}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h4000, '1,
			16'h4000, 16'h0, 22'h0, 22'h0));
		issue_command(cast_cmd({6'd30, 6'd29}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h4000, '1,
			16'h4000, 16'h0, 22'h0, 22'h0_8000));
		issue_command(cast_cmd({6'd40, 6'd39}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h4000, '1,
			16'h0, 16'hC000, 22'h0, 22'h0));
		// door with the solid bit set is open here, the door behind it is not
		issue_command(cast_cmd({6'd40, 6'd42}, 2'b01, 32'h1_0000, 32'h1_0000, 32'h4000, '1,
			16'h0, 16'h0, 22'h0, 22'h0_1234));
		issue_command(cast_cmd({6'd45, 6'd50}, 2'b00, 32'h1_0000, 32'h2_0000, '1, 32'h3000,
			16'h8000, 16'h4000, 22'h3F_FFFF, 22'h0));
		issue_command(cast_cmd({6'd45, 6'd50}, 2'b00, 32'h1_0000, 32'h2_0000, '1, 32'h3000,
			16'h7FFF, 16'h4000, 22'h0, 22'h0));
		issue_command(cast_cmd({6'd55, 6'd50}, 2'b10, 32'h1_0000, 32'h1_5555, '1, 32'hA000,
			16'h1234, 16'hC000, 22'h32_ABCD, 22'h37_5555));
	endtask

	task automatic test_saturation_and_ties();
		gap_max = 12;
		stall_mode <= STALL_LONG;
		issue_command(cast_cmd({6'd9, 6'd10}, 2'b00, 32'h1_0000, 32'h1_0000, 32'h1_0000,
			32'h1_0000, 16'h2D41, 16'h2D41, 22'h0A_8000, 22'h09_8000));
		issue_command(cast_cmd({6'd5, 6'd10}, 2'b00, 32'h1_0000, '1, '1, 32'hFFFF_0000,
			16'h0, 16'h4000, 22'h0, 22'h0));
		// x saturates into a tie with y, and a zero y step keeps the tie
		issue_command(cast_cmd({6'd10, 6'd4}, 2'b00, 32'h80, 32'h0, 32'hFFFF_FF00, '1,
			16'h4000, 16'h0001, 22'h0, 22'h0));
		wait_for_casts();
	endtask

	task automatic test_random_rooms();
		logic [5:0] cx;
		logic [5:0] cy;
		for (int round = 0; round < 13; round++) begin
			case (round % 4)
				0: begin gap_max = 0; stall_mode <= STALL_NONE; end
				1: begin gap_max = 3; stall_mode <= STALL_SHORT; end
				2: begin gap_max = 12; stall_mode <= STALL_LONG; end
				default: begin gap_max = 30; stall_mode <= STALL_SHORT; end
			endcase
			cx = 6'($urandom);
			cy = 6'($urandom);
			for (int i = 0; i < 50; i++) begin
				if (i < 18 || $urandom_range(0, 9) == 0) issue_command(room_load(cx, cy));
				else issue_command(room_ray(cx, cy));
			end
			if (round % 3 == 2) wait_for_casts();
		end
	endtask

	initial begin
		foreach (tile_map[i]) tile_map[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_map();
		test_solid_and_doors();
		test_saturation_and_ties();
		test_random_rooms();
		wait_for_casts();
		repeat (500) @(posedge clk);
		if (mismatch_count == 0 && cast_results_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
